/* rtl/mrb_pkg.sv */
// ----------------------------------------------------------------------------
// mrb_pkg: shared definitions for the message ring buffer
// Default sizes, status codes, request kinds and stream word widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mrb_pkg;

    // Default sizes
    localparam int STORE_DEPTH_DEF = 512;
    localparam int MAX_MESSAGE_DEF = 128;

    // Stream word widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // Result status codes
    typedef logic [2:0] status_t;

    localparam status_t ST_ACCEPTED    = 3'd0;
    localparam status_t ST_COMMITTED   = 3'd1;
    localparam status_t ST_EMPTY_IGN   = 3'd2;
    localparam status_t ST_NO_SPACE    = 3'd3;
    localparam status_t ST_TOO_LONG    = 3'd4;
    localparam status_t ST_POP_EMPTY   = 3'd5;
    localparam status_t ST_POP_NO_TERM = 3'd6;

    // Request kinds carried on tuser
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

endpackage

`default_nettype wire

/* rtl/mrb_ram.sv */
// ----------------------------------------------------------------------------
// mrb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/message_ring_buffer_core.sv */
// ----------------------------------------------------------------------------
// message_ring_buffer_core: ring store of zero-terminated messages
// Push bytes to build a message, a zero byte commits or drops it; pop bytes
// back out of the oldest committed message.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per word. s_tuser selects push (0) or
//   pop (1); s_tdata carries the push byte, zero ending the message.
//   Output stream (m_*): exactly one result word per request, in order.
//   m_tdata holds status, popped byte and the store-empty flag; m_tlast
//   marks the terminator of a popped message.
//   Path: a request taken into the input register is processed and lands
//   in the result register once that register is free or draining, and
//   is offered on m_* from there.
//   Throughput: one request per cycle while m_tready does not stall the
//   result. The byte store RAM's single registered read port is addressed
//   with the next read cursor, so a pop always finds its byte ready at once.
//   Reset: all pointers, the full flag and the staged length clear at once;
//   the byte store itself is not cleared and needs no clearing pass.
//   Stall: a result held on m_* stays stable; one more request is taken
//   into the input register, then s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module message_ring_buffer_core #(
    parameter int STORE_DEPTH = mrb_pkg::STORE_DEPTH_DEF,
    parameter int MAX_MESSAGE = mrb_pkg::MAX_MESSAGE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mrb_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] push_byte
    input  wire logic                          s_tuser,   // [0] req_type
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [2:0] status, [10:3] pop_byte, [11] store_empty, [15:12] zero
    output logic      [mrb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                               m_tlast    // pop_last
);

    localparam int PW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX  = PW'(STORE_DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_F   = FW'(STORE_DEPTH);
    localparam logic [7:0]    STAGE_MAX = 8'(MAX_MESSAGE - 1);
    localparam logic [7:0]    MSG_MAX   = 8'(MAX_MESSAGE);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // Input register
    logic       in_valid_reg;
    logic       req_reg;
    logic [7:0] byte_reg;

    // Ring state
    logic [PW-1:0] rh_reg, rh_next;
    logic [PW-1:0] rc_reg, rc_next;
    logic [PW-1:0] wt_reg, wt_next;
    logic [PW-1:0] wc_reg, wc_next;
    logic          full_reg, full_next;
    logic [7:0]    pend_reg, pend_next;
    logic          lost_reg, lost_next;

    // Result register
    logic                 out_valid_reg;
    mrb_pkg::status_t     status_reg, status_next;
    logic [7:0]           pop_byte_reg, pop_byte_next;
    logic                 last_reg, last_next;
    logic                 empty_reg, empty_next;

    // RAM port and read bypass
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          byp_reg;
    logic [7:0]    byp_data_reg;
    logic [7:0]    rd_byte;

    logic          fire;
    logic          in_take;
    logic [FW-1:0] avail;
    logic [8:0]    pend_inc;
    logic [PW-1:0] rc_adv;
    logic          is_empty;

    // Handshake: process when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    // Free space left by the committed read head
    always_comb
    begin
        if (full_reg)
        begin
            avail = '0;
        end
        else if (rh_reg <= wt_reg)
        begin
            avail = DEPTH_F - FW'(wt_reg) + FW'(rh_reg);
        end
        else
        begin
            avail = FW'(rh_reg) - FW'(wt_reg);
        end
    end

    assign pend_inc = {1'b0, pend_reg} + 9'd1;
    assign is_empty = !full_reg && (rh_reg == wt_reg);
    assign rc_adv   = ring_next(rc_reg);
    assign rd_byte  = byp_reg ? byp_data_reg : ram_rdata;

    // Process one request
    always_comb
    begin
        rh_next       = rh_reg;
        rc_next       = rc_reg;
        wt_next       = wt_reg;
        wc_next       = wc_reg;
        full_next     = full_reg;
        pend_next     = pend_reg;
        lost_next     = lost_reg;
        status_next   = mrb_pkg::ST_ACCEPTED;
        pop_byte_next = '0;
        last_next     = 1'b0;
        ram_we        = 1'b0;
        ram_wdata     = byte_reg;

        if (fire)
        begin
            if (req_reg == mrb_pkg::REQ_PUSH)
            begin
                if (byte_reg != 8'd0)
                begin
                    // Stage a message byte
                    if (pend_reg < STAGE_MAX)
                    begin
                        if (FW'(pend_reg) < avail)
                        begin
                            ram_we = 1'b1;
                        end
                        else
                        begin
                            lost_next = 1'b1;
                        end
                        wc_next = ring_next(wc_reg);
                    end
                    if (pend_reg != 8'hFF)
                    begin
                        pend_next = pend_reg + 8'd1;
                    end
                end
                else
                begin
                    // Terminator: commit or drop the staged message
                    if (pend_reg == 8'd0)
                    begin
                        status_next = mrb_pkg::ST_EMPTY_IGN;
                        wc_next     = wt_reg;
                    end
                    else if (pend_reg >= MSG_MAX)
                    begin
                        status_next = mrb_pkg::ST_TOO_LONG;
                        wc_next     = wt_reg;
                    end
                    else if (lost_reg || (FW'(pend_inc) > avail))
                    begin
                        status_next = mrb_pkg::ST_NO_SPACE;
                        wc_next     = wt_reg;
                    end
                    else
                    begin
                        status_next = mrb_pkg::ST_COMMITTED;
                        ram_we      = 1'b1;
                        wt_next     = ring_next(wc_reg);
                        wc_next     = ring_next(wc_reg);
                        if (FW'(pend_inc) == avail)
                        begin
                            full_next = 1'b1;
                        end
                    end
                    pend_next = '0;
                    lost_next = 1'b0;
                end
            end
            else if (is_empty)
            begin
                status_next = mrb_pkg::ST_POP_EMPTY;
            end
            else
            begin
                // Pop one byte of the oldest message
                pop_byte_next = rd_byte;
                rc_next       = rc_adv;
                if (rd_byte == 8'd0)
                begin
                    rh_next     = rc_adv;
                    full_next   = 1'b0;
                    last_next   = 1'b1;
                    status_next = mrb_pkg::ST_COMMITTED;
                end
                else if (rc_adv == wt_reg)
                begin
                    rc_next     = rh_reg;
                    status_next = mrb_pkg::ST_POP_NO_TERM;
                end
            end
        end

        empty_next = !full_next && (rh_next == wt_next);
    end

    // Byte store, addressed ahead with the next read cursor
    mrb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wc_reg),
        .wdata (ram_wdata),
        .raddr (rc_next),
        .rdata (ram_rdata)
    );

    // Forward a write that hits the address being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= ram_we && (wc_reg == rc_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= ram_wdata;
    end

    // Control and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rh_reg        <= '0;
            rc_reg        <= '0;
            wt_reg        <= '0;
            wc_reg        <= '0;
            full_reg      <= 1'b0;
            pend_reg      <= '0;
            lost_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            rh_reg   <= rh_next;
            rc_reg   <= rc_next;
            wt_reg   <= wt_next;
            wc_reg   <= wc_next;
            full_reg <= full_next;
            pend_reg <= pend_next;
            lost_reg <= lost_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg  <= s_tuser;
            byte_reg <= s_tdata;
        end
        if (fire)
        begin
            status_reg   <= status_next;
            pop_byte_reg <= pop_byte_next;
            last_reg     <= last_next;
            empty_reg    <= empty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, empty_reg, pop_byte_reg, status_reg};

`ifndef ASSERT_OFF
    // A full store has head and tail meeting
    a_full_ptrs : assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (rh_reg == wt_reg))
        else $error("full flag set with head and tail apart");

    // No staged bytes means the write cursor sits on the tail
    a_stage_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 8'd0) |-> (wc_reg == wt_reg))
        else $error("write cursor moved without staged bytes");

    // A lost byte only exists inside a staged message
    a_lost_pend : assert property (@(posedge clk) disable iff (!rst_n)
        lost_reg |-> (pend_reg != 8'd0))
        else $error("lost flag set with nothing staged");

    // The terminator flag only comes with a committed pop
    a_last_status : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == mrb_pkg::ST_COMMITTED))
        else $error("terminator flagged without commit status");
`endif

endmodule

`default_nettype wire
